// ===== design/bfa_pkg.sv =====
`timescale 1ns / 1ps

package bfa_pkg;

  // default sizing
  localparam int unsigned MAX_FRAMES_DEF    = 16384;
  localparam int unsigned MAP_WORD_BITS_DEF = 32;

  // fixed field widths
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned BYTE_ADDR_W = 32;
  localparam int unsigned FADDR_W     = 26;
  localparam int unsigned FCOUNT_W    = 15;
  localparam int unsigned FRAME_SHIFT = 12;
  // frame number of a byte address, and one more bit for limits and range ends
  localparam int unsigned FRAME_W     = BYTE_ADDR_W - FRAME_SHIFT;
  localparam int unsigned FR_W        = FRAME_W + 1;

  localparam logic [BYTE_ADDR_W-1:0] PAGE_MASK = BYTE_ADDR_W'((1 << FRAME_SHIFT) - 1);

  // register file
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic REG_FRAME_COUNT = 1'b0;
  localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RST = FCOUNT_W'(16384);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_RESERVE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_BASE,
    ST_RD,
    ST_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [BYTE_ADDR_W-1:0] address;
    logic [BYTE_ADDR_W-1:0] length;
  } alloc_req_t;

  typedef struct packed {
    logic [FADDR_W-1:0] frame_address;
    logic               found;
  } alloc_rsp_t;

endpackage

// ===== design/bitmap_frame_allocator_unit.sv =====
`timescale 1ns / 1ps

// Page-frame allocator over a one-bit-per-frame busy map held in a RAM.
// Requests arrive on the in channel (valid/ready, alloc_req_t): allocate
// the lowest free frame, free the frame holding an address, or reserve a
// byte range. Every request gives one beat on the out channel
// (valid/ready, alloc_rsp_t); only an allocate that finds a frame reports
// found with the frame's byte address.
// One request is handled at a time. Allocate reads the map one word per
// cycle, overlapping the read of the next word with the check of the
// current one. Free and reserve first locate the map word of the range's
// first frame, then take each map word the range touches in turn: read,
// then modify and write back. A request that touches no map word goes
// straight to the response.
// The limit is min(frame_count, MaxFrames); frame_count is written over
// the APB port while no request is in flight, by the user: the block
// does not enforce it. After reset the RAM is cleared one word per cycle,
// MapWords words (512 at default size); no request is taken till it ends.
// A finished result sits in an output register; while the receiver
// stalls it holds there, and the next result waits in the response state.
module bitmap_frame_allocator_unit import bfa_pkg::*; #(
  parameter int unsigned MaxFrames   = MAX_FRAMES_DEF,
  parameter int unsigned MapWordBits = MAP_WORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  alloc_req_t         in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output alloc_rsp_t         out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned MapWords = (MaxFrames + MapWordBits - 1) / MapWordBits;
  localparam int unsigned WordW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned BitW     = $clog2(MapWordBits);
  localparam int unsigned CntW     = $clog2(MapWordBits + 1);
  // exact quotient by word size through a reciprocal for frame numbers
  localparam int unsigned DivShift = FRAME_W + BitW;
  localparam longint unsigned DivMul =
    ((64'd1 << DivShift) + MapWordBits - 1) / MapWordBits;
  localparam int unsigned DivMulW  = FRAME_W + 2;
  localparam int unsigned ProdW    = FRAME_W + DivMulW;

  localparam logic [FR_W-1:0]  MaxFr     = FR_W'(MaxFrames);
  localparam logic [FR_W-1:0]  WordFr    = FR_W'(MapWordBits);
  localparam logic [CntW-1:0]  WordCnt   = CntW'(MapWordBits);
  localparam logic [WordW-1:0] LastWord  = WordW'(MapWords - 1);
  localparam logic [DivMulW-1:0] DivMulK = DivMulW'(DivMul);

  state_e state_q, state_d;

  logic [FCOUNT_W-1:0]    frame_count_q;
  logic [KIND_W-1:0]      kind_q;
  logic [FRAME_W-1:0]     first_q;
  logic [FR_W-1:0]        stop_q;
  logic [WordW-1:0]       word_q;
  logic [FR_W-1:0]        base_q;
  logic [WordW-1:0]       iss_word_q;
  logic [FR_W-1:0]        iss_base_q;
  logic                   rd_valid_q;
  logic [WordW-1:0]       chk_word_q;
  logic [FR_W-1:0]        chk_base_q;
  logic [FR_W-1:0]        res_frame_q;
  logic                   res_found_q;
  logic [WordW-1:0]       clr_q;
  logic                   out_valid_q;
  alloc_rsp_t             out_data_q;

  logic [MapWordBits-1:0] map_mem [MapWords];
  logic [MapWordBits-1:0] rdata_q;
  logic                   mem_we, mem_re;
  logic [WordW-1:0]       mem_waddr, mem_raddr;
  logic [MapWordBits-1:0] mem_wdata;

  logic                   in_fire, out_load;
  logic [FR_W-1:0]        lim;

  // frame limit
  always_comb begin
    lim = FR_W'(frame_count_q);
    if (lim > MaxFr) begin
      lim = MaxFr;
    end
  end

  // request decode at accept
  logic [BYTE_ADDR_W-1:0] rs_start, rs_end;
  logic [FRAME_W-1:0]     req_first;
  logic [FR_W-1:0]        req_stop, rs_stop_raw, fr_ext;
  logic                   req_range;

  always_comb begin
    rs_start    = in_data_i.address & ~PAGE_MASK;
    rs_end      = (in_data_i.address + in_data_i.length + PAGE_MASK) & ~PAGE_MASK;
    rs_stop_raw = {1'b0, rs_end[BYTE_ADDR_W-1:FRAME_SHIFT]};
    fr_ext      = {1'b0, in_data_i.address[BYTE_ADDR_W-1:FRAME_SHIFT]};
    req_first   = in_data_i.address[BYTE_ADDR_W-1:FRAME_SHIFT];
    req_stop    = '0;
    req_range   = 1'b0;
    if (in_data_i.kind == KIND_FREE) begin
      req_stop  = fr_ext + FR_W'(1);
      req_range = (fr_ext < lim);
    end else if (in_data_i.kind == KIND_RESERVE) begin
      req_stop  = (rs_stop_raw > lim) ? lim : rs_stop_raw;
      req_range = (rs_end > rs_start) && (fr_ext < req_stop);
    end
  end

  // word index of the first frame in a range
  logic [ProdW-1:0] div_prod, div_quot;
  always_comb begin
    div_prod = ProdW'(first_q) * ProdW'(DivMulK);
    div_quot = div_prod >> DivShift;
  end

  // allocate: check of the word read last cycle
  logic [FR_W-1:0]        scan_av;
  logic [CntW-1:0]        scan_cnt;
  logic [MapWordBits-1:0] scan_free;
  logic [BitW-1:0]        scan_idx;
  logic                   found_now, scan_issue;

  always_comb begin
    scan_av  = lim - chk_base_q;
    scan_cnt = (scan_av >= WordFr) ? WordCnt : CntW'(scan_av);
    for (int b = 0; b < MapWordBits; b++) begin
      scan_free[b] = ~rdata_q[b] && (CntW'(b) < scan_cnt);
    end
    scan_idx = '0;
    for (int b = MapWordBits - 1; b >= 0; b--) begin
      if (scan_free[b]) begin
        scan_idx = BitW'(b);
      end
    end
    found_now  = rd_valid_q && (|scan_free);
    scan_issue = (iss_base_q < lim) && !found_now;
  end

  // free and reserve: bits of the current word inside the range
  logic [FR_W-1:0]        rg_lo_diff, rg_hi_diff, rg_next_base;
  logic [CntW-1:0]        rg_lo, rg_hi;
  logic [MapWordBits-1:0] rg_mask;

  always_comb begin
    rg_lo_diff   = {1'b0, first_q} - base_q;
    rg_hi_diff   = stop_q - base_q;
    rg_lo        = ({1'b0, first_q} > base_q) ? CntW'(rg_lo_diff) : '0;
    rg_hi        = (rg_hi_diff >= WordFr) ? WordCnt : CntW'(rg_hi_diff);
    rg_next_base = base_q + WordFr;
    for (int b = 0; b < MapWordBits; b++) begin
      rg_mask[b] = (CntW'(b) >= rg_lo) && (CntW'(b) < rg_hi);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == LastWord) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.kind == KIND_ALLOC) begin
            state_d = ST_SCAN;
          end else if (req_range) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (found_now || (!rd_valid_q && !scan_issue)) begin
          state_d = ST_RESP;
        end
      end
      ST_DIV:  state_d = ST_BASE;
      ST_BASE: state_d = ST_RD;
      ST_RD:   state_d = ST_WR;
      ST_WR:   state_d = (rg_next_base >= stop_q) ? ST_RESP : ST_RD;
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the controller: handshake and map port
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      ST_IDLE: in_ready_o = 1'b1;
      ST_SCAN: begin
        mem_re    = scan_issue;
        mem_raddr = iss_word_q;
        mem_we    = found_now;
        mem_waddr = chk_word_q;
        mem_wdata = rdata_q | (MapWordBits'(1) << scan_idx);
      end
      ST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = word_q;
      end
      ST_WR: begin
        mem_we    = 1'b1;
        mem_waddr = word_q;
        mem_wdata = (kind_q == KIND_RESERVE) ? (rdata_q | rg_mask) : (rdata_q & ~rg_mask);
      end
      ST_RESP: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  // busy map RAM
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= map_mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      frame_count_q <= FRAME_COUNT_RST;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + WordW'(1);
      end
      if (in_fire) begin
        rd_valid_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        rd_valid_q <= scan_issue;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (psel && penable && pwrite && (paddr[2] == REG_FRAME_COUNT)) begin
        frame_count_q <= pwdata[FCOUNT_W-1:0];
      end
    end
  end

  // request and walk registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q      <= in_data_i.kind;
      first_q     <= req_first;
      stop_q      <= req_stop;
      iss_word_q  <= '0;
      iss_base_q  <= '0;
      res_found_q <= 1'b0;
      res_frame_q <= '0;
    end
    if (state_q == ST_SCAN) begin
      if (scan_issue) begin
        iss_word_q <= iss_word_q + WordW'(1);
        iss_base_q <= iss_base_q + WordFr;
        chk_word_q <= iss_word_q;
        chk_base_q <= iss_base_q;
      end
      if (found_now) begin
        res_found_q <= 1'b1;
        res_frame_q <= chk_base_q + FR_W'(scan_idx);
      end
    end
    if (state_q == ST_DIV) begin
      word_q <= div_quot[WordW-1:0];
    end
    if (state_q == ST_BASE) begin
      base_q <= FR_W'(word_q * MapWordBits);
    end
    if (state_q == ST_WR) begin
      word_q <= word_q + WordW'(1);
      base_q <= rg_next_base;
    end
    if (out_load) begin
      out_data_q.found         <= res_found_q;
      out_data_q.frame_address <= {res_frame_q[FADDR_W-FRAME_SHIFT-1:0],
                                   FRAME_SHIFT'(0)};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == REG_FRAME_COUNT) ? PDATA_W'(frame_count_q) : '0;

  // a word under check was issued below the limit
  a_chk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && rd_valid_q) |-> (chk_base_q < lim))
    else $error("scan checks a word beyond the frame limit");

  // the write back never collides with a read of the same word
  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("map read and write hit the same word");

  // only an allocate can report a frame
  a_found_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && res_found_q) |-> (kind_q == KIND_ALLOC))
    else $error("found set for a request that is not an allocate");

  // a new result is loaded only from the response state
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_RESP))
    else $error("result beat raised outside the response state");

  // no request is taken while the map is being cleared
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!in_ready_o && mem_we && !mem_re))
    else $error("request window open during the clearing pass");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import bfa_pkg::*; ();

  localparam logic [KIND_W-1:0]  KIND_UNUSED      = 2'd3;
  localparam logic [PADDR_W-1:0] FRAME_COUNT_ADDR = PADDR_W'(4 * REG_FRAME_COUNT);
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR    = PADDR_W'(4);
  localparam int unsigned        RANDOM_ITEMS     = 1170;
  localparam int unsigned        MAX_SHOWN        = 10;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  alloc_req_t         in_beat   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  alloc_rsp_t         out_beat;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  bitmap_frame_allocator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the allocator state
  bit                  frame_busy [MAX_FRAMES_DEF];
  logic [FCOUNT_W-1:0] frame_count_reg = FRAME_COUNT_RST;

  alloc_req_t  req_backlog [$];
  alloc_rsp_t  rsp_expected [$];
  int unsigned reqs_queued   = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned send_gap      = 0;
  int unsigned stall_left    = 0;
  bit          steady        = 1'b0;
  int unsigned allocs_found  = 0;
  int unsigned allocs_empty  = 0;
  int unsigned frees_done    = 0;
  int unsigned reserves_done = 0;
  int unsigned unused_done   = 0;
  int unsigned counts_used   = 0;
  alloc_rsp_t  want_rsp;

  function automatic int unsigned frame_limit(logic [FCOUNT_W-1:0] cnt);
    return (cnt > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : int'(cnt);
  endfunction

  // first-fit allocate, free and range reserve against the shadow map
  function automatic alloc_rsp_t predict_alloc_rsp(alloc_req_t req);
    alloc_rsp_t             rsp;
    int unsigned            lim;
    int unsigned            fr;
    int unsigned            stop;
    logic [BYTE_ADDR_W-1:0] start_b;
    logic [BYTE_ADDR_W-1:0] end_b;
    rsp = '0;
    lim = frame_limit(frame_count_reg);
    case (req.kind)
      KIND_ALLOC: begin
        fr = 0;
        while (fr < lim && frame_busy[fr]) fr++;
        if (fr < lim) begin
          frame_busy[fr]    = 1'b1;
          rsp.frame_address = FADDR_W'(fr << FRAME_SHIFT);
          rsp.found         = 1'b1;
          allocs_found++;
        end else begin
          allocs_empty++;
        end
      end
      KIND_FREE: begin
        fr = req.address >> FRAME_SHIFT;
        if (fr < lim) frame_busy[fr] = 1'b0;
        frees_done++;
      end
      KIND_RESERVE: begin
        start_b = req.address & ~PAGE_MASK;
        end_b   = req.address + req.length + PAGE_MASK;
        end_b   = end_b & ~PAGE_MASK;
        if (end_b > start_b) begin
          stop = end_b >> FRAME_SHIFT;
          if (stop > lim) stop = lim;
          for (fr = start_b >> FRAME_SHIFT; fr < stop; fr++) frame_busy[fr] = 1'b1;
        end
        reserves_done++;
      end
      default: begin
        unused_done++;
      end
    endcase
    return rsp;
  endfunction

  // idle length: mostly short, a few long
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [FCOUNT_W-1:0] pick_frame_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return FCOUNT_W'($urandom_range(32, 640));
    if (r < 60) return FCOUNT_W'($urandom_range(1, 31));
    if (r < 65) return '0;
    if (r < 80) return FRAME_COUNT_RST;
    if (r < 90) return FCOUNT_W'($urandom_range(16385, 32767));
    return FCOUNT_W'($urandom_range(641, 16383));
  endfunction

  // request mix over frames from zero to just past the limit
  function automatic alloc_req_t make_request(int unsigned lim);
    alloc_req_t  req;
    int unsigned r;
    int unsigned fr;
    r           = $urandom_range(0, 99);
    req.kind    = KIND_ALLOC;
    req.address = $urandom;
    req.length  = $urandom;
    if (r < 44) begin
      req.kind = KIND_ALLOC;
    end else if (r < 74) begin
      req.kind    = KIND_FREE;
      fr          = $urandom_range(0, lim + 7);
      req.address = (fr << FRAME_SHIFT) | $urandom_range(0, 4095);
    end else if (r < 92) begin
      req.kind    = KIND_RESERVE;
      fr          = $urandom_range(0, lim + 3);
      req.address = (fr << FRAME_SHIFT) | $urandom_range(0, 4095);
      r           = $urandom_range(0, 99);
      if (r < 70) req.length = $urandom_range(0, 4 << FRAME_SHIFT);
      else if (r < 92) req.length = $urandom_range(0, 64 << FRAME_SHIFT);
    end else if (r < 95) begin
      req.kind = KIND_UNUSED;
    end else begin
      req.kind = KIND_W'($urandom_range(0, 3));
    end
    return req;
  endfunction

  task automatic push_req(logic [KIND_W-1:0] kind, logic [BYTE_ADDR_W-1:0] addr,
                          logic [BYTE_ADDR_W-1:0] len);
    alloc_req_t req;
    req.kind    = kind;
    req.address = addr;
    req.length  = len;
    req_backlog.push_back(req);
    reqs_queued++;
  endtask

  // sender holds off until every result is back
  task automatic wait_drained();
    while (results_seen < reqs_queued) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == FRAME_COUNT_ADDR) frame_count_reg = data[FCOUNT_W-1:0];
  endtask

  task automatic apb_read_check(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] want);
    logic [PDATA_W-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("register read mismatch: expected %h, got %h", want, got);
    end
  endtask

  task automatic set_frame_count(logic [PDATA_W-1:0] value);
    apb_write(FRAME_COUNT_ADDR, value);
    apb_read_check(FRAME_COUNT_ADDR, PDATA_W'(frame_count_reg));
    counts_used++;
  endtask

  // request driver: one beat held until accepted, prediction at acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) rsp_expected.push_back(predict_alloc_rsp(in_beat));
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_beat  <= req_backlog.pop_front();
          in_valid <= 1'b1;
          if (!steady && $urandom_range(0, 99) < 30) send_gap = pick_pause();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (rsp_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected result beat: addr %h found %b",
                     out_beat.frame_address, out_beat.found);
        end else begin
          want_rsp = rsp_expected.pop_front();
          if (out_beat.frame_address !== want_rsp.frame_address ||
              out_beat.found !== want_rsp.found) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("result mismatch: expected addr %h found %b, got addr %h found %b",
                       want_rsp.frame_address, want_rsp.found,
                       out_beat.frame_address, out_beat.found);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 25) begin
        stall_left = pick_pause() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin
    #(100_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus sequence
  initial begin
    logic [FCOUNT_W-1:0] fc;
    int unsigned         lim;
    int unsigned         n;
    alloc_req_t          req;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default count: frame zero, frees in and out of range, reserve corner cases
    push_req(KIND_ALLOC,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(KIND_ALLOC,   32'h0000_0000, 32'h0000_0000);
    push_req(KIND_FREE,    32'h0000_0FFF, 32'hFFFF_FFFF);
    push_req(KIND_FREE,    32'h0000_0000, 32'h0000_0000);
    push_req(KIND_ALLOC,   32'h0000_0000, 32'h0000_0000);
    push_req(KIND_FREE,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(KIND_RESERVE, 32'h0000_2800, 32'h0000_1801);
    push_req(KIND_ALLOC,   32'h0000_0000, 32'h0000_0000);
    push_req(KIND_RESERVE, 32'hFFFF_F000, 32'h0000_2000);
    push_req(KIND_RESERVE, 32'h0000_0000, 32'h0000_0000);
    push_req(KIND_RESERVE, 32'h0400_0000, 32'h0000_1000);
    push_req(KIND_RESERVE, 32'h03FF_F000, 32'hFFFF_FFFF);
    push_req(KIND_RESERVE, 32'h03FF_F000, 32'h0000_0001);
    push_req(KIND_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(KIND_UNUSED,  32'h0000_0000, 32'h0000_0000);
    push_req(KIND_FREE,    32'h03FF_FABC, 32'h0000_0000);
    wait_drained();

    // no frames present
    set_frame_count(0);
    push_req(KIND_ALLOC,   32'h0000_0000, 32'h0000_0000);
    push_req(KIND_FREE,    32'h0000_0000, 32'h0000_0000);
    push_req(KIND_RESERVE, 32'h0000_0000, 32'h0001_0000);
    wait_drained();

    // single frame, then out-of-range write must leave the count alone
    set_frame_count(1);
    apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    apb_read_check(FRAME_COUNT_ADDR, PDATA_W'(frame_count_reg));
    push_req(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000);
    push_req(KIND_FREE,  32'h0000_0123, 32'h0000_0000);
    push_req(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000);
    push_req(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000);
    wait_drained();

    // count above the map saturates; reserve the whole map
    set_frame_count(32767);
    push_req(KIND_RESERVE, 32'h0000_0000, 32'h0400_0000);
    push_req(KIND_ALLOC,   32'h0000_0000, 32'h0000_0000);
    push_req(KIND_FREE,    32'h0123_4567, 32'h0000_0000);
    push_req(KIND_ALLOC,   32'h0000_0000, 32'h0000_0000);
    wait_drained();
    set_frame_count(16383);

    // random phases, one frame count each
    while (reqs_queued < RANDOM_ITEMS) begin
      fc = pick_frame_count();
      set_frame_count(PDATA_W'(fc));
      if ($urandom_range(0, 3) == 0) begin
        apb_write(UNMAPPED_ADDR, $urandom);
        apb_read_check(FRAME_COUNT_ADDR, PDATA_W'(frame_count_reg));
      end
      lim    = frame_limit(fc);
      steady = ($urandom_range(0, 5) == 0);
      n      = (lim > 640) ? $urandom_range(20, 50) : $urandom_range(40, 110);
      repeat (n) begin
        if (reqs_queued < RANDOM_ITEMS) begin
          req = make_request(lim);
          push_req(req.kind, req.address, req.length);
        end
      end
      wait_drained();
    end
    steady = 1'b0;
    repeat (20) @(posedge clk_i);

    $display("covered %0d requests over %0d frame-count writes: %0d allocs found, %0d empty",
             reqs_queued, counts_used, allocs_found, allocs_empty);
    $display("also %0d frees, %0d range reserves, %0d unused-kind requests",
             frees_done, reserves_done, unused_done);
    if (mismatches == 0 && rsp_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
